FILE: sv/wclm_pkg.sv
// Package with shared types and constants of the windowed CPU load meter.
package wclm_pkg;
  localparam int StoreDepth = 128;
  localparam int IdxW = $clog2(StoreDepth);
  localparam int CntW = IdxW + 1;
  localparam int TimeW = 63;
  localparam int WinW = 40;
  localparam int CpuW = 9;
  localparam int LoadW = 10;
  localparam logic [LoadW-1:0] LoadFull = 10'd1000;
  localparam logic [0:0] CfgWindow = 1'b0;
  localparam logic [0:0] CfgCpus = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_CHECK, ST_SPACE, ST_DIVB, ST_DIVD, ST_LOADA, ST_LOADC, ST_OUT
  } wclm_state_t;

  typedef struct packed {
    logic start;
    logic [TimeW-1:0] num;
    logic [TimeW-1:0] den;
    logic perm;
  } wclm_div_req_t;
endpackage

FILE: sv/wclm_div.sv
// Bit-serial divider: plain quotient or min(num*1000/den, 1000).
module wclm_div
  import wclm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  wclm_div_req_t       req,
  output logic                done,
  output logic [TimeW-1:0]    quot
);
  localparam int DW = 2 * TimeW + 10;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [TimeW:0] rem_r, rem_nxt;
  logic [TimeW-1:0] q_r, q_nxt, den_r, den_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, perm_r, perm_nxt, full_r, full_nxt, done_r, done_nxt;
  logic [TimeW:0] sh;

  always_comb begin
    dvd_nxt = dvd_r; rem_nxt = rem_r; q_nxt = q_r; den_nxt = den_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; perm_nxt = perm_r; full_nxt = full_r;
    done_nxt = 1'b0;
    sh = {rem_r[TimeW-1:0], dvd_r[DW-1]};
    if (req.start) begin
      den_nxt = req.den; perm_nxt = req.perm; rem_nxt = '0; q_nxt = '0;
      busy_nxt = 1'b1; cnt_nxt = 8'(DW);
      full_nxt = req.perm && (req.den == '0 || req.num >= req.den);
      // Multiply by 1000 as shifted adds: 1024 - 16 - 8.
      dvd_nxt = req.perm ? (({(DW-TimeW)'(0), req.num} << 10)
                           - ({(DW-TimeW)'(0), req.num} << 4)
                           - ({(DW-TimeW)'(0), req.num} << 3))
                         : {req.num, (DW-TimeW)'(0)};
      if (!req.perm) cnt_nxt = 8'(TimeW);
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r}; q_nxt = {q_r[TimeW-2:0], 1'b1};
      end else begin
        rem_nxt = sh; q_nxt = {q_r[TimeW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_r == 8'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt; rem_r <= rem_nxt; q_r <= q_nxt; den_r <= den_nxt;
    perm_r <= perm_nxt; full_r <= full_nxt;
  end

  assign done = done_r;
  assign quot = (perm_r && (full_r || q_r > TimeW'(LoadFull))) ? TimeW'(LoadFull) : q_r;
endmodule

FILE: sv/wclm_store.sv
// Sample store: one memory holding time and busy of each stored sample.
module wclm_store
  import wclm_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic [IdxW-1:0]       waddr,
  input  logic [2*TimeW-1:0]    wdata,
  input  logic [IdxW-1:0]       raddr,
  output logic [2*TimeW-1:0]    rdata
);
  logic [2*TimeW-1:0] mem [StoreDepth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/windowed_cpu_load_meter.sv
// Top level of the windowed CPU load meter.
// Steps per input beat: scan the stored samples for the oldest one in the window, check
// the spacing to the newest entry, then run two busy divisions and two load divisions.
// One sample at a time: a new beat is taken only after the result of the last one has
// been accepted at the output.
// Reset (synchronous, rst_n low) empties the store and restores the register defaults.
module windowed_cpu_load_meter
  import wclm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [127:0]       in_tdata,   // sample_time[62:0], busy_time[125:63], zero fill
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [151:0]       out_tdata,  // average_load, current_load, windowed, span_time,
                                         // busy_delta, zero fill
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [WinW-1:0]    cfg_wdata
);
  wclm_state_t st_r, st_nxt;
  logic [WinW-1:0] win_r;
  logic [CpuW-1:0] cpus_r;
  logic [IdxW-1:0] newest_r, newest_nxt, ridx_r, ridx_nxt;
  logic [CntW-1:0] count_r, count_nxt, k_r, k_nxt;
  logic [TimeW-1:0] ts_r, busy_r, span_r, span_nxt, delta_r, delta_nxt;
  logic [TimeW-1:0] bq_r, bq_nxt, dq_r, dq_nxt;
  logic [LoadW-1:0] avg_r, avg_nxt, cur_r, cur_nxt;
  logic found_r, found_nxt, ovalid_r, ovalid_nxt;
  logic [TimeW-1:0] age, etime, ebusy;
  logic [2*TimeW-1:0] rdata;
  logic we;
  wclm_div_req_t dreq;
  logic ddone, dwait_r, dwait_nxt;
  logic [TimeW-1:0] dquot;
  // The scan sets ridx to the newest entry as it enters ST_SPACE; space_rd_r holds
  // ST_SPACE while the registered memory read of that entry completes.
  logic space_rd_r;
  logic [WinW+6:0] age100;
  logic space_far;

  assign etime = rdata[TimeW-1:0];
  assign ebusy = rdata[2*TimeW-1:TimeW];
  assign age = ts_r - etime;

  // For whole numbers, age > window / 100 holds exactly when 100 * age > window.
  // Any age at or above 2^40 is beyond every window.
  assign age100 = {1'b0, age[WinW-1:0], 6'd0} + {2'b0, age[WinW-1:0], 5'd0}
                + {5'd0, age[WinW-1:0], 2'd0};
  assign space_far = (age[TimeW-1:WinW] != '0) || (age100 > {7'd0, win_r});

  wclm_store u_store (
    .clk, .we, .waddr(newest_r + IdxW'(1)), .wdata({busy_r, ts_r}),
    .raddr(ridx_r), .rdata
  );
  wclm_div u_div (.clk, .rst_n, .req(dreq), .done(ddone), .quot(dquot));

  assign in_tready = (st_r == ST_IDLE);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_tvalid) st_nxt = ST_READ;
      ST_READ:  st_nxt = (k_r == count_r) ? ST_SPACE : ST_CHECK;
      ST_CHECK: st_nxt = (age < TimeW'(win_r)) ? ST_SPACE : ST_READ;
      ST_SPACE: st_nxt = ST_DIVB;
      ST_DIVB:  if (ddone) st_nxt = ST_DIVD;
      ST_DIVD:  if (ddone) st_nxt = ST_LOADA;
      ST_LOADA: if (ddone) st_nxt = ST_LOADC;
      ST_LOADC: if (ddone) st_nxt = ST_OUT;
      ST_OUT:   if (!ovalid_r) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    newest_nxt = newest_r; ridx_nxt = ridx_r; count_nxt = count_r; k_nxt = k_r;
    span_nxt = span_r; delta_nxt = delta_r; found_nxt = found_r;
    bq_nxt = bq_r; dq_nxt = dq_r; avg_nxt = avg_r; cur_nxt = cur_r;
    ovalid_nxt = ovalid_r && !out_tready;
    we = 1'b0; dwait_nxt = 1'b0;
    dreq = '{start: 1'b0, num: '0, den: '0, perm: 1'b0};
    unique case (st_r)
      ST_IDLE: begin
        k_nxt = '0; found_nxt = 1'b0;
        span_nxt = in_tdata[TimeW-1:0]; delta_nxt = in_tdata[2*TimeW-1:TimeW];
        ridx_nxt = newest_r + IdxW'(1) - count_r[IdxW-1:0];
      end
      ST_READ: ;
      ST_CHECK: begin
        if (age < TimeW'(win_r)) begin
          found_nxt = 1'b1; span_nxt = age; delta_nxt = busy_r - ebusy;
          count_nxt = count_r - k_r;
        end else begin
          k_nxt = k_r + CntW'(1); ridx_nxt = ridx_r + IdxW'(1);
        end
      end
      ST_SPACE: ;
      ST_DIVB, ST_DIVD, ST_LOADA, ST_LOADC: begin
        dwait_nxt = 1'b1;
        if (!dwait_r) begin
          dreq.start = 1'b1;
          dreq.den = (cpus_r == '0) ? TimeW'(1) : TimeW'(cpus_r);
          dreq.perm = 1'b0;
          case (st_r)
            ST_DIVB: dreq.num = busy_r;
            ST_DIVD: dreq.num = delta_r;
            ST_LOADA: begin dreq.num = bq_r; dreq.den = ts_r; dreq.perm = 1'b1; end
            default: begin dreq.num = dq_r; dreq.den = span_r; dreq.perm = 1'b1; end
          endcase
        end
        if (ddone) begin
          dwait_nxt = 1'b0;
          case (st_r)
            ST_DIVB: bq_nxt = dquot;
            ST_DIVD: dq_nxt = dquot;
            ST_LOADA: avg_nxt = dquot[LoadW-1:0];
            default: begin cur_nxt = dquot[LoadW-1:0]; ovalid_nxt = 1'b1; end
          endcase
        end
      end
      ST_OUT: ;
      default: ;
    endcase
    // Spacing check reads the newest entry; it is valid in ST_SPACE once space_rd_r is set.
    if (st_r == ST_SPACE && space_rd_r && (count_r == '0 || space_far)) begin
      we = 1'b1; newest_nxt = newest_r + IdxW'(1);
      if (count_r != CntW'(StoreDepth)) count_nxt = count_r + CntW'(1);
    end
    if (st_nxt == ST_SPACE && st_r != ST_SPACE) ridx_nxt = newest_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; win_r <= WinW'(1000000000); cpus_r <= CpuW'(1);
      newest_r <= '0; count_r <= '0; ovalid_r <= 1'b0; dwait_r <= 1'b0;
      space_rd_r <= 1'b0;
    end else begin
      if (st_r == ST_SPACE && !space_rd_r) begin
        space_rd_r <= 1'b1;
      end else begin
        space_rd_r <= 1'b0;
        st_r <= st_nxt; newest_r <= newest_nxt; count_r <= count_nxt;
      end
      ovalid_r <= ovalid_nxt; dwait_r <= dwait_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgWindow: win_r <= cfg_wdata;
          CfgCpus:   cpus_r <= cfg_wdata[CpuW-1:0];
          default: ;
        endcase
      end
    end
    if (!(st_r == ST_SPACE && !space_rd_r)) begin
      ridx_r <= ridx_nxt; k_r <= k_nxt; span_r <= span_nxt; delta_r <= delta_nxt;
      found_r <= found_nxt; bq_r <= bq_nxt; dq_r <= dq_nxt;
      avg_r <= avg_nxt; cur_r <= cur_nxt;
    end
    if (st_r == ST_IDLE && in_tvalid) begin
      ts_r <= in_tdata[TimeW-1:0]; busy_r <= in_tdata[2*TimeW-1:TimeW];
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {5'd0, delta_r, span_r, found_r, cur_r, avg_r};
endmodule

FILE: sv/wclm_checker.sv
// Port-level checker for the windowed CPU load meter, bound to the top level.
module wclm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [151:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out held");
  a_avg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:0] <= 10'd1000) else $error("average range");
  a_cur: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[19:10] <= 10'd1000) else $error("current range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accepting while result pending");
endmodule

bind windowed_cpu_load_meter wclm_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

FILE: tb/tb_top.sv
// Self-checking testbench for the windowed CPU load meter: stream stimulus and a scoreboard.
module tb_top;
  import wclm_pkg::*;

  // Expected result of one sample, in the order the fields sit in out_tdata.
  typedef struct {
    logic [LoadW-1:0] avg_load;
    logic [LoadW-1:0] cur_load;
    logic             in_window;
    logic [TimeW-1:0] span;
    logic [TimeW-1:0] busy_delta;
  } load_result_t;

  // Scoreboard: mirrors the sample store and keeps the queue of pending results.
  class load_scoreboard;
    logic [TimeW-1:0] sample_ts [StoreDepth];
    logic [TimeW-1:0] sample_busy [StoreDepth];
    int unsigned      newest;
    int unsigned      stored;
    logic [WinW-1:0]  window_ns;
    logic [CpuW-1:0]  cpus;
    load_result_t     pending[$];
    int               mismatches;

    function new();
      newest = 0;
      stored = 0;
      window_ns = 40'd1000000000;
      cpus = 9'd1;
      mismatches = 0;
    endfunction

    // floor(num * 1000 / den), clamped to full scale; a zero divisor reads as full.
    function logic [LoadW-1:0] permille(logic [TimeW-1:0] num, logic [TimeW-1:0] den);
      logic [127:0] q;
      if (den == 0 || num >= den) return LoadFull;
      q = ({65'd0, num} * 128'd1000) / {65'd0, den};
      return (q > 1000) ? LoadFull : q[LoadW-1:0];
    endfunction

    function void note_sample(logic [TimeW-1:0] ts, logic [TimeW-1:0] busy);
      load_result_t r;
      logic [TimeW-1:0] age, span, delta;
      logic [CpuW-1:0] div;
      int unsigned oldest, k, idx;
      bit found;
      found = 0;
      span = ts;
      delta = busy;
      age = 0;
      idx = 0;
      div = (cpus == 0) ? 9'd1 : cpus;
      oldest = (newest + StoreDepth + 1 - stored) % StoreDepth;
      for (k = 0; k < stored; k++) begin
        idx = (oldest + k) % StoreDepth;
        age = ts - sample_ts[idx];
        if ({1'b0, age} < {24'd0, window_ns}) begin
          found = 1;
          break;
        end
      end
      if (found) begin
        span = age;
        delta = busy - sample_busy[idx];
        stored -= k;
      end
      if (stored == 0 || {1'b0, ts - sample_ts[newest]} > {24'd0, window_ns / 100}) begin
        newest = (newest + 1) % StoreDepth;
        sample_ts[newest] = ts;
        sample_busy[newest] = busy;
        if (stored < StoreDepth) stored++;
      end
      r.avg_load = permille(busy / div, ts);
      r.cur_load = permille(delta / div, span);
      r.in_window = found;
      r.span = span;
      r.busy_delta = delta;
      pending.push_back(r);
    endfunction

    function void check_result(logic [151:0] data);
      load_result_t e;
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %h", data);
        return;
      end
      e = pending.pop_front();
      bad = (data[9:0] !== e.avg_load) || (data[19:10] !== e.cur_load) ||
            (data[20] !== e.in_window) || (data[83:21] !== e.span) ||
            (data[146:84] !== e.busy_delta) || (data[151:147] !== 5'd0);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected avg %0d cur %0d win %0d span %0d delta %0d",
                   e.avg_load, e.cur_load, e.in_window, e.span, e.busy_delta);
          $display("          actual   avg %0d cur %0d win %0d span %0d delta %0d",
                   data[9:0], data[19:10], data[20], data[83:21], data[146:84]);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [127:0]       in_tdata;   // sample_time, busy_time, zero fill
  logic               out_tvalid;
  logic               out_tready;
  logic [151:0]       out_tdata;  // average_load, current_load, windowed, span_time, busy_delta
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [WinW-1:0]    cfg_wdata;

  load_scoreboard sb;
  bit  hold_off;        // long receiver stall requested by the stimulus
  logic [TimeW-1:0] clock_ns;   // running timestamp of the well-formed sample stream
  logic [TimeW-1:0] busy_ns;    // running cumulative busy time

  windowed_cpu_load_meter dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Generous fixed limit on the whole run: it allows the slowest sample, with the longest
  // gaps on both sides, several times over for every sample sent.
  initial begin
    #(8 * 16000000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Gap lengths are mostly short with an occasional long one.
  function int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Sends one sample beat and notes it in the scoreboard at acceptance.
  // Valid stays high after acceptance until a gap or drain() lowers it.
  task send_sample(logic [TimeW-1:0] ts, logic [TimeW-1:0] busy);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, busy, ts};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(ts, busy);
  endtask

  // Waits until every pending result is back, then lets the block settle.
  task drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(logic [0:0] idx, logic [WinW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgWindow) sb.window_ns = value;
    else sb.cpus = value[CpuW-1:0];
    @(posedge clk);
  endtask

  // Advances the sample stream by a step scaled to the window; busy grows at a random rate.
  task step_stream(logic [WinW-1:0] win, int unsigned cpus);
    logic [TimeW-1:0] dt;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) dt = win / $urandom_range(2, 60);
    else if (p < 70) dt = win / $urandom_range(100, 400);
    else if (p < 85) dt = win + $urandom_range(0, 1000);
    else if (p < 92) dt = 0;
    else dt = {$urandom, $urandom} % ({23'd0, win} * 3 + 1);
    clock_ns += dt;
    busy_ns += ({$urandom, $urandom} % (dt + 1)) * $urandom_range(1, cpus);
    send_sample(clock_ns, busy_ns);
  endtask

  // Receiver: random stalls, plus the long hold-off requested by the stimulus.
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) stall = 3000;
      else stall = gap_len();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid) sb.check_result(out_tdata);
    end
  end

  // Main stimulus.
  initial begin
    logic [WinW-1:0] win;
    int unsigned cpus, n;
    logic [TimeW-1:0] all_ones;
    sb = new();
    hold_off = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_index = CfgWindow;
    cfg_wdata = '0;
    all_ones = '1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings: extremes, zero divisors, wrap cases.
    send_sample(0, 0);
    send_sample(0, all_ones);
    send_sample(all_ones, all_ones);
    send_sample(all_ones, 0);
    send_sample(63'd5, 63'd3);            // time wraps past all ones to a small age
    send_sample(63'd1000000, 63'd999999);
    send_sample(63'd1000001, 63'd2);      // busy going backwards
    send_sample(63'd500000000, 63'd200000000);
    send_sample(63'd505000001, 63'd204000000);
    send_sample(63'h2AAAAAAAAAAAAAAA, 63'h1555555555555555);
    send_sample(63'h5555555555555555, 63'h2AAAAAAAAAAAAAAA);
    drain();

    // Zero window and zero cpu count are corner settings of the registers.
    write_reg(CfgWindow, 40'd0);
    write_reg(CfgCpus, 40'd0);
    send_sample(63'd100, 63'd50);
    send_sample(63'd100, 63'd60);
    send_sample(63'd200, 63'd70);
    drain();
    write_reg(CfgWindow, 40'hFF_FFFF_FFFF);
    write_reg(CfgCpus, 40'd511);
    send_sample(63'd10, 63'd5);
    send_sample(63'd20, all_ones);
    send_sample(63'd30, 63'd7);
    drain();

    // Random phases: well-formed streams with random content, some noise samples.
    clock_ns = 0;
    busy_ns = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin win = 40'd1000000000; cpus = 1; end
        1: begin win = 40'd100; cpus = 256; end
        2: begin win = 40'd1000000000000; cpus = 4; end
        default: begin
          win = {$urandom, $urandom} % 40'd1000000000000 + 100;
          cpus = $urandom_range(1, 256);
        end
      endcase
      write_reg(CfgWindow, win);
      write_reg(CfgCpus, cpus);
      n = (ph == 2) ? 250 : 190;
      for (int i = 0; i < n; i++) begin
        if (ph == 1 && i == 40) hold_off = 1;
        if (ph == 1 && i == 45) hold_off = 0;
        if ($urandom_range(0, 19) == 0)
          send_sample({$urandom, $urandom}, {$urandom, $urandom});
        else
          step_stream(win, cpus);
      end
      drain();
    end

    drain();
    if (sb.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
